// ===== rtl/core/sha1md_pkg.sv =====
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest core.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DIGEST_WORDS = 5;
  localparam int BLOCK_WORDS  = 16;
  localparam int IDX_W        = $clog2(DIGEST_WORDS);

  localparam logic [31:0] INIT_WORDS [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_ROUND0 = 32'h5a827999;
  localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
  localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] PAD_LIMIT = 6'd56;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } item_t;

  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } qstat_t;

endpackage

// ===== rtl/core/sha1_message_digest_core.sv =====
// ----------------------------------------------------------------------------
// sha1_message_digest_core
// SHA-1 over a byte stream, five digest words out per message.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel: one byte per transfer (byte_present), end_of_message closes
//   the message; an item with neither is dropped. A four-entry queue sits in
//   front of the engine, so msg_ready falls only when that queue is full.
//   digest channel: five transfers per message, word_index 0 to 4, last_word
//   on the fifth. While the receiver stalls the word is held and the engine
//   waits; the queue keeps taking bytes until it fills.
// Timing:
//   The engine absorbs one byte per cycle while it is idle; each full 64-byte
//   block then runs the 80 rounds in the single round unit and the chaining
//   add, and no bytes are taken from the queue until that is done.
//   After end_of_message, padding is written one byte per cycle up to the
//   block end (one or two more compressions), then the digest words follow,
//   one per cycle when not stalled.
// Reset: rst clears the queue and loads the initial hash words; no clearing
//   pass is needed and the block is ready in the next cycle.
// ----------------------------------------------------------------------------
module sha1_message_digest_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          msg_valid,
  output logic                          msg_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          byte_present,
  input  logic                          end_of_message,
  output logic                          digest_valid,
  input  logic                          digest_ready,
  output logic [31:0]                   digest_word,
  output logic [sha1md_pkg::IDX_W-1:0]  word_index,
  output logic                          last_word
);
  import sha1md_pkg::*;

  item_t  push;
  item_t  head;
  qstat_t stat;
  logic   pop;

  sha1md_front u_front (
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .stat           (stat),
    .push           (push)
  );

  sha1md_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .stat (stat)
  );

  sha1md_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  // queue occupancy stays within its depth
  a_queue_bound : assert property (@(posedge clk) disable iff (rst)
    stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // digest words leave in order, one index per transfer
  a_word_advance : assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && !last_word |=>
      digest_valid && (word_index == $past(word_index) + 1'b1))
    else $error("digest word index did not advance");

  // the final word ends the digest
  a_last_ends : assert property (@(posedge clk) disable iff (rst)
    digest_valid && digest_ready && last_word |=> !digest_valid)
    else $error("digest output continued past the last word");

  // nothing is popped while the digest is being delivered
  a_no_pop_out : assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> !pop)
    else $error("queue popped during digest output");

endmodule

// ===== rtl/core/sha1md_front.sv =====
// ----------------------------------------------------------------------------
// sha1md_front
// Input side: takes message items and queues those that carry work.
// ----------------------------------------------------------------------------
module sha1md_front (
  input  logic                msg_valid,
  output logic                msg_ready,
  input  logic [7:0]          data_byte,
  input  logic                byte_present,
  input  logic                end_of_message,
  input  sha1md_pkg::qstat_t  stat,
  output sha1md_pkg::item_t   push
);
  import sha1md_pkg::*;

  assign msg_ready = !stat.full;

  // drop items with neither a byte nor an end mark: they change nothing
  always_comb begin
    push.valid                = msg_valid && msg_ready && (byte_present || end_of_message);
    push.entry.data_byte      = data_byte;
    push.entry.byte_present   = byte_present;
    push.entry.end_of_message = end_of_message;
  end

endmodule

// ===== rtl/core/sha1md_queue.sv =====
// ----------------------------------------------------------------------------
// sha1md_queue
// Short FIFO between the input side and the hashing engine.
// ----------------------------------------------------------------------------
module sha1md_queue (
  input  logic               clk,
  input  logic               rst,
  input  sha1md_pkg::item_t  push,
  input  logic               pop,
  output sha1md_pkg::item_t  head,
  output sha1md_pkg::qstat_t stat
);
  import sha1md_pkg::*;

  entry_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.count = count;
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  assign do_push = push.valid && !stat.full;
  assign do_pop  = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

endmodule

// ===== rtl/core/sha1md_back.sv =====
// ----------------------------------------------------------------------------
// sha1md_back
// Hashing engine: byte packing, padding, 80-round compression and digest out.
// ----------------------------------------------------------------------------
module sha1md_back (
  input  logic                          clk,
  input  logic                          rst,
  input  sha1md_pkg::item_t             head,
  output logic                          pop,
  output logic                          digest_valid,
  input  logic                          digest_ready,
  output logic [31:0]                   digest_word,
  output logic [sha1md_pkg::IDX_W-1:0]  word_index,
  output logic                          last_word
);
  import sha1md_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PAD   = 5'b00010,
    S_ROUND = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  localparam logic [6:0] RND_STAGE1 = 7'd20;
  localparam logic [6:0] RND_STAGE2 = 7'd40;
  localparam logic [6:0] RND_STAGE3 = 7'd60;
  localparam logic [6:0] RND_LAST   = 7'd79;
  localparam logic [5:0] FILL_LAST  = 6'd63;

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill;
  logic [63:0] byte_count;
  logic [31:8] partial;
  logic [31:0] sched [BLOCK_WORDS];
  logic [31:0] chain [DIGEST_WORDS];
  logic [31:0] a, b, c, d, e;
  logic [6:0]  rnd;
  logic        pend_eom;
  logic        in_pad;
  logic        pad_first;
  logic        pad_wrap;
  logic        len_done;
  logic [IDX_W-1:0] out_idx;

  logic        ins_en;
  logic [7:0]  ins_byte;
  logic        full;
  logic        pad_len_sel;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic        shift_en;
  logic [31:0] shift_word;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sched_mix;
  logic [31:0] t;
  logic        out_done;

  assign pop = (state == S_IDLE) && head.valid;

  // padding byte selection
  assign bit_len     = {byte_count[60:0], 3'b000};
  assign len_byte    = bit_len[{~fill[2:0], 3'b000} +: 8];
  assign pad_len_sel = !pad_first && !pad_wrap && (fill >= PAD_LIMIT);
  assign pad_byte    = pad_first ? PAD_BYTE : (pad_len_sel ? len_byte : 8'h00);

  always_comb begin
    ins_en   = 1'b0;
    ins_byte = head.entry.data_byte;
    if (state == S_IDLE) begin
      ins_en = pop && head.entry.byte_present;
    end else if (state == S_PAD) begin
      ins_en   = 1'b1;
      ins_byte = pad_byte;
    end
  end

  assign full = ins_en && (fill == FILL_LAST);

  // round function
  always_comb begin
    if (rnd < RND_STAGE1) begin
      f = (b & c) | (~b & d);
      k = K_ROUND0;
    end else if (rnd < RND_STAGE2) begin
      f = b ^ c ^ d;
      k = K_ROUND1;
    end else if (rnd < RND_STAGE3) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_ROUND2;
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND3;
    end
  end

  assign sched_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign t = {a[26:0], a[31:27]} + f + e + k + sched[0];

  // the schedule window advances on each packed word and on each round
  always_comb begin
    shift_en   = 1'b0;
    shift_word = {partial[31:8], ins_byte};
    if (state == S_ROUND) begin
      shift_en   = 1'b1;
      shift_word = {sched_mix[30:0], sched_mix[31]};
    end else if (ins_en && (fill[1:0] == 2'd3)) begin
      shift_en = 1'b1;
    end
  end

  assign out_done = digest_ready && (out_idx == IDX_W'(DIGEST_WORDS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (pop) begin
          if (full) begin
            state_next = S_ROUND;
          end else if (head.entry.end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (full) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (rnd == RND_LAST) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        if (len_done) begin
          state_next = S_OUT;
        end else if (in_pad || pend_eom) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      byte_count <= '0;
      rnd        <= '0;
      pend_eom   <= 1'b0;
      in_pad     <= 1'b0;
      pad_first  <= 1'b0;
      pad_wrap   <= 1'b0;
      len_done   <= 1'b0;
      out_idx    <= '0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= INIT_WORDS[i];
      end
    end else begin
      state <= state_next;
      if (ins_en) begin
        fill <= fill + 1'b1;
      end
      if (pop && head.entry.byte_present) begin
        byte_count <= byte_count + 64'd1;
      end
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            pend_eom <= head.entry.end_of_message;
            if (!full && head.entry.end_of_message) begin
              in_pad    <= 1'b1;
              pad_first <= 1'b1;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          // a mark too late for the length forces an extra block of zeros and the length
          if (full) begin
            pad_wrap <= 1'b0;
          end else if (pad_first) begin
            pad_wrap <= (fill >= PAD_LIMIT);
          end
          if (full && pad_len_sel) begin
            len_done <= 1'b1;
          end
        end
        S_ROUND: begin
          rnd <= (rnd == RND_LAST) ? '0 : rnd + 1'b1;
        end
        S_ADD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          chain[4] <= chain[4] + e;
          if (!in_pad && pend_eom) begin
            in_pad    <= 1'b1;
            pad_first <= 1'b1;
          end
          pend_eom <= 1'b0;
        end
        S_OUT: begin
          if (out_done) begin
            // re-initialise for the next message
            out_idx    <= '0;
            byte_count <= '0;
            in_pad     <= 1'b0;
            len_done   <= 1'b0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
              chain[i] <= INIT_WORDS[i];
            end
          end else if (digest_ready) begin
            out_idx <= out_idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // the last byte of a word goes straight into the window
    if (ins_en) begin
      case (fill[1:0])
        2'd0:    partial[31:24] <= ins_byte;
        2'd1:    partial[23:16] <= ins_byte;
        2'd2:    partial[15:8]  <= ins_byte;
        default: begin
        end
      endcase
    end
    if (shift_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[BLOCK_WORDS - 1] <= shift_word;
    end
    if (full) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == S_ROUND) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  assign digest_valid = (state == S_OUT);
  assign digest_word  = chain[out_idx];
  assign word_index   = out_idx;
  assign last_word    = (out_idx == IDX_W'(DIGEST_WORDS - 1));

endmodule

// ===== dv/sha1_message_digest_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_message_digest_core_tb
// Self-checking bench for the byte-serial SHA-1 core. Messages of random
// length and content are streamed in, with extra empty items mixed in. A
// class-based SHA-1 tracker predicts the five digest words of every message
// and checks each word transfer in order. Idling on both channels is varied
// by phase, and one long digest hold-off forces the input queue to fill.
// ----------------------------------------------------------------------------
module sha1_message_digest_core_tb;

  import sha1md_pkg::*;

  typedef struct {
    logic [31:0]      word;
    logic [IDX_W-1:0] index;
    logic             last;
  } digest_word_t;

  class sha1_digest_tracker;
    bit [31:0]    chain [DIGEST_WORDS];
    bit [31:0]    block [BLOCK_WORDS];
    bit [63:0]    byte_total;
    int unsigned  fill;
    digest_word_t expected_words [$];
    int           mismatches;
    int           words_checked;
    int           messages_closed;

    function new();
      clear_message();
      mismatches      = 0;
      words_checked   = 0;
      messages_closed = 0;
    endfunction

    function void clear_message();
      foreach (chain[i]) chain[i] = INIT_WORDS[i];
      foreach (block[i]) block[i] = '0;
      byte_total = '0;
      fill       = 0;
    endfunction

    // Big-endian placement; the first byte of a word clears it.
    function void put_byte(bit [7:0] b);
      int unsigned w;
      w = fill >> 2;
      if ((fill & 3) == 0) block[w] = '0;
      block[w] |= 32'(b) << (24 - 8 * (fill & 3));
      fill = (fill + 1) & 63;
    endfunction

    function void compress();
      bit [31:0] sched [BLOCK_WORDS];
      bit [31:0] a, b, c, d, e, f, k, t, x;
      int unsigned s;
      sched = block;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int r = 0; r < 80; r++) begin
        s = r & 15;
        if (r >= 16) begin
          x = sched[(s + 13) & 15] ^ sched[(s + 8) & 15] ^ sched[(s + 2) & 15] ^ sched[s];
          sched[s] = {x[30:0], x[31]};
        end
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K_ROUND0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K_ROUND1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_ROUND2;
        end else begin
          f = b ^ c ^ d;
          k = K_ROUND3;
        end
        t = {a[26:0], a[31:27]} + f + e + k + sched[s];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // Note one accepted msg transfer; a closing item queues the digest.
    function void absorb_item(bit [7:0] data, bit present, bit closing);
      bit [63:0]    bit_len;
      digest_word_t dw;
      if (present) begin
        put_byte(data);
        byte_total++;
        if (fill == 0) compress();
      end
      if (!closing) return;
      bit_len = byte_total << 3;
      put_byte(PAD_BYTE);
      if (fill == 0) begin
        compress();
      end else if (fill > PAD_LIMIT) begin
        while (fill != 0) put_byte(8'h00);
        compress();
      end
      while (fill < PAD_LIMIT) put_byte(8'h00);
      block[14] = bit_len[63:32];
      block[15] = bit_len[31:0];
      fill      = 0;
      compress();
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        dw.word  = chain[i];
        dw.index = IDX_W'(i);
        dw.last  = (i == DIGEST_WORDS - 1);
        expected_words.push_back(dw);
      end
      messages_closed++;
      clear_message();
    endfunction

    function void check_word(logic [31:0] word, logic [IDX_W-1:0] index, logic last);
      digest_word_t dw;
      words_checked++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected digest word %h idx %0d last %b",
                   $realtime, word, index, last);
        return;
      end
      dw = expected_words.pop_front();
      if (word !== dw.word || index !== dw.index || last !== dw.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: digest mismatch: exp %h idx %0d last %b, got %h idx %0d last %b",
                   $realtime, dw.word, dw.index, dw.last, word, index, last);
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                msg_valid = 1'b0;
  logic                msg_ready;
  logic [7:0]          data_byte = 8'h00;
  logic                byte_present = 1'b0;
  logic                end_of_message = 1'b0;
  logic                digest_valid;
  logic                digest_ready = 1'b0;
  logic [31:0]         digest_word;
  logic [IDX_W-1:0]    word_index;
  logic                last_word;

  sha1_digest_tracker  tracker = new();
  int                  sender_idle_pct = 0;
  int                  receiver_stall_pct = 0;
  int                  hold_left = 0;
  int                  counted_items = 0;
  int                  bytes_sent = 0;
  int                  queue_full_cycles = 0;

  always #5 clk = ~clk;

  sha1_message_digest_core dut (
    .clk            (clk),
    .rst            (rst),
    .msg_valid      (msg_valid),
    .msg_ready      (msg_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_ready   (digest_ready),
    .digest_word    (digest_word),
    .word_index     (word_index),
    .last_word      (last_word)
  );

  // Digest receiver: a long hold takes priority over random stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        digest_ready = 1'b0;
        hold_left--;
      end else begin
        digest_ready = !(receiver_stall_pct != 0 &&
                         $urandom_range(1, 100) <= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && digest_valid && digest_ready)
      tracker.check_word(digest_word, word_index, last_word);
    if (!rst && msg_valid && !msg_ready)
      queue_full_cycles++;
  end

  // Offer one item and hold it until the transfer completes.
  task automatic send_item(input logic [7:0] data, input logic present, input logic closing);
    while (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
      msg_valid = 1'b0;
      data_byte = 8'($urandom);
      @(negedge clk);
    end
    msg_valid      = 1'b1;
    data_byte      = data;
    byte_present   = present;
    end_of_message = closing;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    tracker.absorb_item(data, present, closing);
    if (present || closing) counted_items++;
    if (present) bytes_sent++;
    @(negedge clk);
    msg_valid = 1'b0;
  endtask

  // Random bytes with occasional empty items; the end flag rides on the last
  // byte or on a separate empty-byte item.
  task automatic send_message(input int len);
    bit end_with_byte;
    end_with_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(1, 100) <= 5) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_with_byte && (i == len - 1));
    end
    if (!end_with_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    int phase_target;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ignored item, empty message, lone byte closing, "abc", zero byte
    // then a separate close, bytes 80 7F; both closes are empty items with all-ones data
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 47; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 47; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      // hold the digest side long enough for the input queue to back up
      if (phase == 0) hold_left = 600;
      // the last message of a phase may overshoot the target
      phase_target = counted_items + 45;
      while (counted_items < phase_target) begin
        case ($urandom_range(0, 9))
          6:       len = $urandom_range(55, 57);
          7:       len = $urandom_range(63, 64);
          8:       len = $urandom_range(100, 130);
          9:       len = $urandom_range(1, 8);
          default: len = $urandom_range(0, 24);
        endcase
        send_message(len);
      end
    end

    while (tracker.pending() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    $display("Run covered %0d messages, %0d bytes, %0d digest words checked.",
             tracker.messages_closed, bytes_sent, tracker.words_checked);
    $display("Input queue stalled the sender for %0d cycles in total.", queue_full_cycles);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("sha1_message_digest_core_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d words still expected", tracker.mismatches,
               tracker.pending());
      $display("sha1_message_digest_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout with %0d digest words still expected", tracker.pending());
    $display("sha1_message_digest_core_tb: FAIL");
    $finish;
  end

endmodule
